// ----- sv/ihex_pkg.sv -----
// ----------------------------------------------------------------------------
// ihex_pkg: shared types and constants of the hex record loader
// Event and error codes, record types, the result record and the digit decode.
// ----------------------------------------------------------------------------
package ihex_pkg;

  typedef enum logic [1:0] {
    EV_WRITE = 2'd0,
    EV_EOF   = 2'd1,
    EV_ERROR = 2'd2
  } event_kind_t;

  typedef enum logic [2:0] {
    ERR_CHECKSUM = 3'd0,
    ERR_SEGMENT  = 3'd1,
    ERR_LINEAR   = 3'd2,
    ERR_START    = 3'd3,
    ERR_TYPE     = 3'd4
  } error_code_t;

  localparam logic [7:0] REC_DATA      = 8'h00;
  localparam logic [7:0] REC_EOF       = 8'h01;
  localparam logic [7:0] REC_EXT_SEG   = 8'h02;
  localparam logic [7:0] REC_START_SEG = 8'h03;
  localparam logic [7:0] REC_EXT_LIN   = 8'h04;
  localparam logic [7:0] REC_START_LIN = 8'h05;

  localparam logic [7:0] CHAR_COLON    = 8'h3a;
  localparam logic [7:0] OFFSET_LEN    = 8'd2;
  localparam logic [7:0] START_LEN     = 8'd4;

  typedef struct packed {
    event_kind_t event_kind;
    logic [31:0] write_address;
    logic [31:0] write_data;
    logic        write_word;
    logic        entry_valid;
    logic [31:0] entry_point;
    error_code_t error_code;
  } result_t;

  // Hex digit value; anything that is not a hex digit reads as zero.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h37);
    end
    return v;
  endfunction

endpackage

// ----- sv/ihex_if.sv -----
// ----------------------------------------------------------------------------
// ihex_char_if / ihex_event_if: valid/ready channels of the hex record loader
// One character channel in, one event channel out.
// ----------------------------------------------------------------------------
interface ihex_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface ihex_event_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [31:0] write_address;
  logic [31:0] write_data;
  logic        write_word;
  logic        entry_valid;
  logic [31:0] entry_point;
  logic [2:0]  error_code;

  modport source (output valid, output event_kind, output write_address,
                  output write_data, output write_word, output entry_valid,
                  output entry_point, output error_code, input ready);
  modport sink   (input valid, input event_kind, input write_address,
                  input write_data, input write_word, input entry_valid,
                  input entry_point, input error_code, output ready);
endinterface

// ----- sv/ihex_in_stage.sv -----
// ----------------------------------------------------------------------------
// ihex_in_stage: input character register
// Holds one character until the parser consumes it; refills in the same cycle.
// ----------------------------------------------------------------------------
module ihex_in_stage (
  input  logic        clk,
  input  logic        rst_n,
  ihex_char_if.sink   in_if,
  input  logic        consume,
  output logic        char_valid,
  output logic [7:0]  char_data
);

  logic       valid_r;
  logic [7:0] char_r;

  assign in_if.ready = !valid_r || consume;
  assign char_valid  = valid_r;
  assign char_data   = char_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_if.ready) begin
      valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      char_r <= in_if.char_in;
    end
  end

endmodule

// ----- sv/ihex_parser.sv -----
// ----------------------------------------------------------------------------
// ihex_parser: record state machine
// Decodes one character per step and produces at most one result.
// ----------------------------------------------------------------------------
module ihex_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        char_data,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  output logic              res_valid,
  output ihex_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_HEADER, PH_DATA, PH_CHECK, PH_HALTED, PH_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        low_next_r, low_next_nxt;
  logic [3:0]  high_nib_r, high_nib_nxt;
  logic [1:0]  hdr_idx_r, hdr_idx_nxt;
  logic [7:0]  rec_len_r, rec_len_nxt;
  logic [15:0] rec_addr_r, rec_addr_nxt;
  logic [7:0]  rec_type_r, rec_type_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [1:0]  group_r, group_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] waddr_r, waddr_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] start_r, start_nxt;
  logic        start_seen_r, start_seen_nxt;
  logic        use_entry_r;

  logic [3:0]  nib;
  logic [7:0]  byte_val;
  logic [7:0]  sum_add;
  logic        addr_zero;

  assign nib       = ihex_pkg::hex_nibble(char_data);
  assign byte_val  = {high_nib_r, nib};
  assign sum_add   = 8'(sum_r + byte_val);
  assign addr_zero = (rec_addr_r == 16'd0);

  always_comb begin
    phase_nxt      = phase_r;
    low_next_nxt   = low_next_r;
    high_nib_nxt   = high_nib_r;
    hdr_idx_nxt    = hdr_idx_r;
    rec_len_nxt    = rec_len_r;
    rec_addr_nxt   = rec_addr_r;
    rec_type_nxt   = rec_type_r;
    sum_nxt        = sum_r;
    left_nxt       = left_r;
    group_nxt      = group_r;
    acc_nxt        = acc_r;
    waddr_nxt      = waddr_r;
    offset_nxt     = offset_r;
    start_nxt      = start_r;
    start_seen_nxt = start_seen_r;
    res_valid      = 1'b0;
    res            = '0;

    unique case (phase_r)
      PH_HALTED, PH_DONE: begin
      end
      PH_HUNT: begin
        if (char_data == ihex_pkg::CHAR_COLON) begin
          phase_nxt    = PH_HEADER;
          hdr_idx_nxt  = 2'd0;
          sum_nxt      = 8'd0;
          low_next_nxt = 1'b0;
        end
      end
      default: begin
        if (!low_next_r) begin
          high_nib_nxt = nib;
          low_next_nxt = 1'b1;
        end else begin
          low_next_nxt = 1'b0;
          sum_nxt      = sum_add;
          unique case (phase_r)
            PH_HEADER: begin
              unique case (hdr_idx_r)
                2'd0: rec_len_nxt = byte_val;
                2'd1: rec_addr_nxt = {byte_val, 8'h00};
                2'd2: rec_addr_nxt = {rec_addr_r[15:8], rec_addr_r[7:0] | byte_val};
                default: begin
                  rec_type_nxt = byte_val;
                  left_nxt     = rec_len_r;
                  group_nxt    = 2'd0;
                  acc_nxt      = 32'd0;
                  waddr_nxt    = 32'(offset_r + {16'd0, rec_addr_r});
                  phase_nxt    = (rec_len_r != 8'd0) ? PH_DATA : PH_CHECK;
                end
              endcase
              hdr_idx_nxt = 2'(hdr_idx_r + 2'd1);
            end
            PH_DATA: begin
              left_nxt = 8'(left_r - 8'd1);
              if (left_r == 8'd1) begin
                phase_nxt = PH_CHECK;
              end
              if (rec_type_r == ihex_pkg::REC_DATA) begin
                if (group_r != 2'd0 || left_r >= 8'd4) begin
                  acc_nxt   = {acc_r[23:0], byte_val};
                  group_nxt = 2'(group_r + 2'd1);
                  if (group_r == 2'd3) begin
                    res_valid         = 1'b1;
                    res.event_kind    = ihex_pkg::EV_WRITE;
                    res.write_address = waddr_r;
                    res.write_data    = {acc_r[23:0], byte_val};
                    res.write_word    = 1'b1;
                    waddr_nxt         = 32'(waddr_r + 32'd4);
                  end
                end else begin
                  res_valid         = 1'b1;
                  res.event_kind    = ihex_pkg::EV_WRITE;
                  res.write_address = waddr_r;
                  res.write_data    = {24'd0, byte_val};
                  res.write_word    = 1'b0;
                  waddr_nxt         = 32'(waddr_r + 32'd1);
                end
              end else begin
                acc_nxt = {acc_r[23:0], byte_val};
              end
            end
            default: begin
              // Checksum byte: test the sum first, then the record layout.
              phase_nxt = PH_HUNT;
              if (sum_add != 8'd0) begin
                phase_nxt      = PH_HALTED;
                res_valid      = 1'b1;
                res.event_kind = ihex_pkg::EV_ERROR;
                res.error_code = ihex_pkg::ERR_CHECKSUM;
              end else begin
                priority case (rec_type_r)
                  ihex_pkg::REC_DATA: begin
                  end
                  ihex_pkg::REC_EOF: begin
                    phase_nxt       = PH_DONE;
                    res_valid       = 1'b1;
                    res.event_kind  = ihex_pkg::EV_EOF;
                    res.entry_valid = start_seen_r && use_entry_r;
                    res.entry_point = (start_seen_r && use_entry_r) ? start_r : 32'd0;
                  end
                  ihex_pkg::REC_EXT_SEG, ihex_pkg::REC_EXT_LIN: begin
                    if (!addr_zero || rec_len_r != ihex_pkg::OFFSET_LEN) begin
                      phase_nxt      = PH_HALTED;
                      res_valid      = 1'b1;
                      res.event_kind = ihex_pkg::EV_ERROR;
                      res.error_code = (rec_type_r == ihex_pkg::REC_EXT_SEG) ?
                                       ihex_pkg::ERR_SEGMENT : ihex_pkg::ERR_LINEAR;
                    end else if (rec_type_r == ihex_pkg::REC_EXT_SEG) begin
                      offset_nxt = {12'd0, acc_r[15:0], 4'd0};
                    end else begin
                      offset_nxt = {acc_r[15:0], 16'd0};
                    end
                  end
                  ihex_pkg::REC_START_SEG, ihex_pkg::REC_START_LIN: begin
                    if (!addr_zero || rec_len_r != ihex_pkg::START_LEN) begin
                      phase_nxt      = PH_HALTED;
                      res_valid      = 1'b1;
                      res.event_kind = ihex_pkg::EV_ERROR;
                      res.error_code = ihex_pkg::ERR_START;
                    end else begin
                      start_seen_nxt = 1'b1;
                      start_nxt      = acc_r;
                    end
                  end
                  default: begin
                    phase_nxt      = PH_HALTED;
                    res_valid      = 1'b1;
                    res.event_kind = ihex_pkg::EV_ERROR;
                    res.error_code = ihex_pkg::ERR_TYPE;
                  end
                endcase
              end
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      low_next_r   <= 1'b0;
      high_nib_r   <= 4'd0;
      hdr_idx_r    <= 2'd0;
      rec_len_r    <= 8'd0;
      rec_addr_r   <= 16'd0;
      rec_type_r   <= 8'd0;
      sum_r        <= 8'd0;
      left_r       <= 8'd0;
      group_r      <= 2'd0;
      acc_r        <= 32'd0;
      waddr_r      <= 32'd0;
      offset_r     <= 32'd0;
      start_r      <= 32'd0;
      start_seen_r <= 1'b0;
      use_entry_r  <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        use_entry_r <= cfg_wr_data;
      end
      if (step) begin
        phase_r      <= phase_nxt;
        low_next_r   <= low_next_nxt;
        high_nib_r   <= high_nib_nxt;
        hdr_idx_r    <= hdr_idx_nxt;
        rec_len_r    <= rec_len_nxt;
        rec_addr_r   <= rec_addr_nxt;
        rec_type_r   <= rec_type_nxt;
        sum_r        <= sum_nxt;
        left_r       <= left_nxt;
        group_r      <= group_nxt;
        acc_r        <= acc_nxt;
        waddr_r      <= waddr_nxt;
        offset_r     <= offset_nxt;
        start_r      <= start_nxt;
        start_seen_r <= start_seen_nxt;
      end
    end
  end

endmodule

// ----- sv/ihex_out_stage.sv -----
// ----------------------------------------------------------------------------
// ihex_out_stage: result register
// Holds one event until the receiver takes it.
// ----------------------------------------------------------------------------
module ihex_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              res_valid,
  input  ihex_pkg::result_t res,
  output logic              advance,
  ihex_event_if.source      out_if
);

  logic              valid_r;
  ihex_pkg::result_t res_r;

  assign advance = !valid_r || out_if.ready;

  assign out_if.valid         = valid_r;
  assign out_if.event_kind    = res_r.event_kind;
  assign out_if.write_address = res_r.write_address;
  assign out_if.write_data    = res_r.write_data;
  assign out_if.write_word    = res_r.write_word;
  assign out_if.entry_valid   = res_r.entry_valid;
  assign out_if.entry_point   = res_r.entry_point;
  assign out_if.error_code    = res_r.error_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= load && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// ----- sv/intel_hex_record_loader.sv -----
// ----------------------------------------------------------------------------
// intel_hex_record_loader: streaming hex file record loader
// Parses hex file text one character at a time into memory writes and events.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one text character per item (valid/ready).
//   out_if : one event per item - a memory write (word or byte), end of file
//            with the optional entry point, or a record error.
//   cfg_wr_en / cfg_wr_data : write the use-entry-point bit (reset 1).
// Timing: an accepted item waits in the input register, is parsed from there,
//   and any event that it yields goes to the result register for out_if.
//   One character is taken every cycle while out_if does not stall; the rate is
//   set by the single parse step between the input and result registers.
// Reset: synchronous, rst_n low. The parser hunts for a ':' and all offsets,
//   the entry point and both stage registers clear.
// Stall: when out_if is not ready and an event is pending, the parser holds;
//   the input register takes a character only if empty, then in_if.ready drops.
// After an end of file or an error event the block drops every character
//   until the next reset.
// ----------------------------------------------------------------------------
module intel_hex_record_loader (
  input  logic         clk,
  input  logic         rst_n,
  ihex_char_if.sink    in_if,
  ihex_event_if.source out_if,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data
);

  logic              char_valid;
  logic [7:0]        char_data;
  logic              advance;
  logic              step;
  logic              res_valid;
  ihex_pkg::result_t res;

  // Advance the parser only when a character waits and the result slot is free.
  assign step = char_valid && advance;

  ihex_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .consume    (step),
    .char_valid (char_valid),
    .char_data  (char_data)
  );

  ihex_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .char_data   (char_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res_valid   (res_valid),
    .res         (res)
  );

  ihex_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_if    (out_if)
  );

endmodule

// ----- sv/ihex_checker.sv -----
// ----------------------------------------------------------------------------
// ihex_checker: port-level checks of the hex record loader
// Watches the event channel; attached to the top level by bind.
// ----------------------------------------------------------------------------
module ihex_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_event_kind,
  input logic [31:0] out_write_data,
  input logic        out_write_word,
  input logic        out_entry_valid,
  input logic [31:0] out_entry_point,
  input logic [2:0]  out_error_code
);

  // A stalled event holds its kind and write data.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_event_kind) &&
                                   $stable(out_write_data)))
    else $error("event changed while stalled");

  // After an end of file or an error is taken, out_valid drops.
  a_terminal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && (out_event_kind == ihex_pkg::EV_EOF ||
                                out_event_kind == ihex_pkg::EV_ERROR)) |=> !out_valid)
    else $error("event after end of stream");

  // Byte writes carry only the low byte.
  a_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind == ihex_pkg::EV_WRITE && !out_write_word)
      |-> (out_write_data[31:8] == 24'd0))
    else $error("byte write with upper bits set");

  // Entry point fields are clear outside end of file.
  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind != ihex_pkg::EV_EOF)
      |-> (!out_entry_valid && out_entry_point == 32'd0))
    else $error("entry point outside end of file");

  // Error codes stay in range.
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind == ihex_pkg::EV_ERROR)
      |-> (out_error_code <= ihex_pkg::ERR_TYPE))
    else $error("error code out of range");

endmodule

bind intel_hex_record_loader ihex_checker u_ihex_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_event_kind  (out_if.event_kind),
  .out_write_data  (out_if.write_data),
  .out_write_word  (out_if.write_word),
  .out_entry_valid (out_if.entry_valid),
  .out_entry_point (out_if.entry_point),
  .out_error_code  (out_if.error_code)
);
